// ===== rtl/sparse_row_product_accumulator_macros.svh =====
// Assertion shorthands shared by the RTL.
`ifndef SPARSE_ROW_PRODUCT_ACCUMULATOR_MACROS_SVH
`define SPARSE_ROW_PRODUCT_ACCUMULATOR_MACROS_SVH

// Same-cycle implication, checked at each rising edge outside reset.
`define SRPA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srpa: same-cycle check failed");

// Next-cycle implication, checked at each rising edge outside reset.
`define SRPA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srpa: next-cycle check failed");

`endif

// ===== rtl/srpa_pkg.sv =====
`default_nettype none

package srpa_pkg;

    // Accumulator depth and the index width that follows from it.
    localparam int COLUMNS = 64;
    localparam int IDX_W   = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

    // Fixed field widths.
    localparam int COL_W   = 6;
    localparam int DATA_W  = 32;
    localparam int VAL_W   = 48;
    localparam int PROD_W  = 2 * DATA_W;
    localparam int FRAC_W  = 16;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_FLUSH = 4'b0010,
        ST_READ  = 4'b0100,
        ST_SEND  = 4'b1000
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/sparse_row_product_accumulator.sv =====
`default_nettype none

// Channel  | Handshake                 | Payload
// ---------+---------------------------+--------------------------------------------------
// input    | i_in_valid / o_in_ready   | i_a_value, i_b_column, i_b_value,
//          |                           | i_has_product, i_end_of_row
// output   | o_out_valid / i_out_ready | o_column, o_value, o_last_in_row, o_row_empty
//
// Flow: one product word per cycle while idle; capture on accept, read + multiply, then add +
// write back. A row-end word stalls input through a flush (until the last product is
// written back), then through a read and an output load for each emitted column.
// Reset: synchronous, active low; clears the bitmap, pipeline valids and output slot.
// The accumulator memory is not cleared: the bitmap guards it.
// Stalls: the output register holds a word until taken; the drain waits on it.

`include "sparse_row_product_accumulator_macros.svh"

module sparse_row_product_accumulator (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,

    input  wire logic                                i_in_valid,
    output      logic                                o_in_ready,
    input  wire logic signed [srpa_pkg::DATA_W-1:0]  i_a_value,
    input  wire logic        [srpa_pkg::COL_W-1:0]   i_b_column,
    input  wire logic signed [srpa_pkg::DATA_W-1:0]  i_b_value,
    input  wire logic                                i_has_product,
    input  wire logic                                i_end_of_row,

    output      logic                                o_out_valid,
    input  wire logic                                i_out_ready,
    output      logic        [srpa_pkg::COL_W-1:0]   o_column,
    output      logic signed [srpa_pkg::VAL_W-1:0]   o_value,
    output      logic                                o_last_in_row,
    output      logic                                o_row_empty
);

    localparam int COLUMNS = srpa_pkg::COLUMNS;
    localparam int IDX_W   = srpa_pkg::IDX_W;
    localparam int VAL_W   = srpa_pkg::VAL_W;

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    srpa_pkg::t_state r_state, n_state;

    // Occupancy bitmap: one bit per accumulator entry, cleared during the drain.
    logic [COLUMNS-1:0] r_occ;

    logic in_fire;
    logic out_fire;
    logic out_free;

    assign o_in_ready = (r_state == srpa_pkg::ST_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign out_fire   = o_out_valid && i_out_ready;
    // The output slot can take a new word this cycle.
    assign out_free   = !o_out_valid || i_out_ready;

    // ------------------------------------------------------------------
    // Stage 1: capture the pair and read the accumulator entry
    // ------------------------------------------------------------------
    logic                               r_s1_valid;
    logic        [IDX_W-1:0]            r_s1_idx;
    logic signed [srpa_pkg::DATA_W-1:0] r_s1_a;
    logic signed [srpa_pkg::DATA_W-1:0] r_s1_b;
    logic                               col_in_range;

    assign col_in_range = ({1'b0, i_b_column} < (srpa_pkg::COL_W + 1)'(COLUMNS));

    // ------------------------------------------------------------------
    // Stage 2: product ready, read data ready; add and write back
    // ------------------------------------------------------------------
    logic                               r_s2_valid;
    logic        [IDX_W-1:0]            r_s2_idx;
    logic signed [VAL_W-1:0]            r_s2_prod;
    logic signed [srpa_pkg::PROD_W-1:0] prod_full;

    assign prod_full = r_s1_a * r_s1_b;

    // Last write, kept to forward into a back-to-back hit on the same entry.
    logic                    r_wb_valid;
    logic [IDX_W-1:0]        r_wb_idx;
    logic signed [VAL_W-1:0] r_wb_data;

    // Accumulator memory, one synchronous read port, one write port.
    logic signed [VAL_W-1:0] mem [COLUMNS];
    logic signed [VAL_W-1:0] r_rdata;
    logic [IDX_W-1:0]        rd_addr;

    logic signed [VAL_W-1:0] acc_old;
    logic signed [VAL_W:0]   acc_sum;
    logic signed [VAL_W-1:0] acc_sat;
    logic signed [VAL_W-1:0] wr_data;
    logic                    entry_occ;

    assign acc_old   = (r_wb_valid && (r_wb_idx == r_s2_idx)) ? r_wb_data : r_rdata;
    assign acc_sum   = {acc_old[VAL_W-1], acc_old} + {r_s2_prod[VAL_W-1], r_s2_prod};
    assign entry_occ = r_occ[r_s2_idx];

    always_comb begin
        // Clamp when the two top bits of the grown sum disagree.
        if (acc_sum[VAL_W] != acc_sum[VAL_W-1]) begin
            acc_sat = acc_sum[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}}
                                     : {1'b0, {(VAL_W-1){1'b1}}};
        end else begin
            acc_sat = acc_sum[VAL_W-1:0];
        end
        // First touch of a column loads the product.
        wr_data = entry_occ ? acc_sat : r_s2_prod;
    end

    // ------------------------------------------------------------------
    // Drain: pick the lowest occupied column each round
    // ------------------------------------------------------------------
    logic [COLUMNS-1:0] low_bit;
    logic [COLUMNS-1:0] occ_rest;
    logic [IDX_W-1:0]   low_idx;
    logic [IDX_W-1:0]   r_drain_idx;
    logic               r_drain_last;

    assign low_bit  = r_occ & (~r_occ + COLUMNS'(1));
    assign occ_rest = r_occ & ~low_bit;

    always_comb begin
        low_idx = '0;
        for (int i = 0; i < COLUMNS; i++) begin
            if (low_bit[i]) begin
                low_idx = low_idx | IDX_W'(i);
            end
        end
    end

    assign rd_addr = (r_state == srpa_pkg::ST_READ) ? low_idx : r_s1_idx;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            srpa_pkg::ST_IDLE: begin
                if (in_fire && i_end_of_row) begin
                    n_state = srpa_pkg::ST_FLUSH;
                end
            end
            srpa_pkg::ST_FLUSH: begin
                // Wait until the row's last write has landed.
                if (!r_s1_valid && !r_s2_valid) begin
                    if (r_occ == '0) begin
                        if (out_free) begin
                            n_state = srpa_pkg::ST_IDLE;
                        end
                    end else begin
                        n_state = srpa_pkg::ST_READ;
                    end
                end
            end
            srpa_pkg::ST_READ: begin
                if (out_free) begin
                    n_state = srpa_pkg::ST_SEND;
                end
            end
            srpa_pkg::ST_SEND: begin
                n_state = r_drain_last ? srpa_pkg::ST_IDLE : srpa_pkg::ST_READ;
            end
            default: begin
                n_state = srpa_pkg::ST_IDLE;
            end
        endcase
    end

    // Memory: read before write on the same edge.
    always_ff @(posedge i_clk) begin
        if (r_s2_valid) begin
            mem[r_s2_idx] <= wr_data;
        end
        r_rdata <= mem[rd_addr];
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_idx <= i_b_column[IDX_W-1:0];
            r_s1_a   <= i_a_value;
            r_s1_b   <= i_b_value;
        end
        r_s2_idx  <= r_s1_idx;
        // Drop the 16 low fraction bits: Q32.32 down to Q32.16.
        r_s2_prod <= prod_full[srpa_pkg::FRAC_W +: VAL_W];
        r_wb_idx  <= r_s2_idx;
        r_wb_data <= wr_data;
        if (r_state == srpa_pkg::ST_READ && out_free) begin
            r_drain_idx  <= low_idx;
            r_drain_last <= (occ_rest == '0);
        end
    end

    // Control registers and the output slot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= srpa_pkg::ST_IDLE;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_wb_valid  <= 1'b0;
            r_occ       <= '0;
            o_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_s1_valid <= in_fire && i_has_product && col_in_range;
            r_s2_valid <= r_s1_valid;
            r_wb_valid <= r_s2_valid;

            if (r_s2_valid) begin
                r_occ[r_s2_idx] <= 1'b1;
            end else if (r_state == srpa_pkg::ST_READ && out_free) begin
                r_occ <= occ_rest;
            end

            // Load wins over a take in the same cycle; otherwise a take empties the slot.
            if (r_state == srpa_pkg::ST_FLUSH && !r_s1_valid && !r_s2_valid
                    && r_occ == '0 && out_free) begin
                o_out_valid <= 1'b1;
            end else if (r_state == srpa_pkg::ST_SEND) begin
                o_out_valid <= 1'b1;
            end else if (out_fire) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // Output payload: load the empty-row word or the drained entry.
    always_ff @(posedge i_clk) begin
        if (r_state == srpa_pkg::ST_FLUSH && !r_s1_valid && !r_s2_valid
                && r_occ == '0 && out_free) begin
            o_column      <= '0;
            o_value       <= '0;
            o_last_in_row <= 1'b1;
            o_row_empty   <= 1'b1;
        end else if (r_state == srpa_pkg::ST_SEND) begin
            o_column      <= srpa_pkg::COL_W'(r_drain_idx);
            o_value       <= r_rdata;
            o_last_in_row <= r_drain_last;
            o_row_empty   <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `SRPA_ASSERT_IMP(a_drain_no_write, i_clk, i_rst_n,
        r_state == srpa_pkg::ST_READ || r_state == srpa_pkg::ST_SEND,
        !r_s1_valid && !r_s2_valid)
    `SRPA_ASSERT_IMP(a_send_slot_free, i_clk, i_rst_n,
        r_state == srpa_pkg::ST_SEND, !o_out_valid)
    `SRPA_ASSERT_IMP(a_read_has_entry, i_clk, i_rst_n,
        r_state == srpa_pkg::ST_READ, r_occ != '0)
    `SRPA_ASSERT_IMP(a_last_clears_map, i_clk, i_rst_n,
        r_state == srpa_pkg::ST_SEND && r_drain_last, r_occ == '0)
    `SRPA_ASSERT_NXT(a_read_to_send, i_clk, i_rst_n,
        r_state == srpa_pkg::ST_READ && out_free, r_state == srpa_pkg::ST_SEND)

endmodule

`default_nettype wire

// ===== sim/tb_sparse_row_product_accumulator.sv =====
`timescale 1ns / 100ps

module tb_sparse_row_product_accumulator;

    localparam int COLUMNS = srpa_pkg::COLUMNS;
    localparam int COL_W   = srpa_pkg::COL_W;
    localparam int DATA_W  = srpa_pkg::DATA_W;
    localparam int VAL_W   = srpa_pkg::VAL_W;
    localparam int PROD_W  = srpa_pkg::PROD_W;
    localparam int FRAC_W  = srpa_pkg::FRAC_W;

    // Quiet cycles (no word moving on either side) before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 5000;
    // Cycles to keep watching after the last expected word, to catch extra words.
    localparam int TAIL_CYCLES    = 200;
    // Counted random words per idling phase; the stalled-receiver phase runs a
    // single full sweep row, which alone exceeds this.
    localparam int PHASE_ITEMS    = 12;
    localparam int MAX_REPORTS    = 10;

    localparam logic signed [VAL_W-1:0]  SUM_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0]  SUM_MIN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] Q_MAX   = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] Q_MIN   = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] Q_ONE   = 32'sh0001_0000;

    typedef struct packed {
        logic [COL_W-1:0]        column;
        logic signed [VAL_W-1:0] value;
        logic                    last_in_row;
        logic                    row_empty;
    } t_row_result;

    // Tracks the dense row accumulator and the touched-column bitmap, and holds
    // the output words each row end must produce, oldest first.
    class row_scoreboard;
        logic signed [VAL_W-1:0] col_sum [COLUMNS];
        logic [COLUMNS-1:0]      touched;
        t_row_result             expected_q [$];
        int unsigned             mismatches;

        function new();
            touched    = '0;
            mismatches = 0;
        endfunction

        // Q16.16 times Q16.16 gives Q32.32; drop 16 fraction bits (floor), keep 48.
        function logic signed [VAL_W-1:0] scaled_product(logic signed [DATA_W-1:0] a,
                                                         logic signed [DATA_W-1:0] b);
            logic signed [PROD_W-1:0] full;
            full = a * b;
            return full[FRAC_W +: VAL_W];
        endfunction

        function logic signed [VAL_W-1:0] clamped_sum(logic signed [VAL_W-1:0] x,
                                                      logic signed [VAL_W-1:0] y);
            logic signed [VAL_W:0] sum;
            sum = x + y;
            if (sum[VAL_W] != sum[VAL_W-1])
                return sum[VAL_W] ? SUM_MIN : SUM_MAX;
            return sum[VAL_W-1:0];
        endfunction

        // Accumulate first, then drain on row end in ascending column order.
        function void note_word(logic signed [DATA_W-1:0] a, logic [COL_W-1:0] col,
                                logic signed [DATA_W-1:0] b, logic prod, logic eor);
            t_row_result r;
            logic signed [VAL_W-1:0] p;
            if (prod && col < COLUMNS) begin
                p = scaled_product(a, b);
                if (touched[col]) begin
                    col_sum[col] = clamped_sum(col_sum[col], p);
                end else begin
                    col_sum[col] = p;
                    touched[col] = 1'b1;
                end
            end
            if (!eor)
                return;
            if (touched == '0) begin
                r = '{column: '0, value: '0, last_in_row: 1'b1, row_empty: 1'b1};
                expected_q = {expected_q, r};
                return;
            end
            for (int c = 0; c < COLUMNS; c++) begin
                if (touched[c]) begin
                    r.column      = c[COL_W-1:0];
                    r.value       = col_sum[c];
                    r.last_in_row = ((touched >> (c + 1)) == '0);
                    r.row_empty   = 1'b0;
                    expected_q = {expected_q, r};
                end
            end
            touched = '0;
        endfunction

        function void flag(string what, logic [63:0] want, logic [63:0] got);
            if (mismatches < MAX_REPORTS)
                $display("%0t: %s: expected %0h, got %0h", $time, what, want, got);
            mismatches++;
        endfunction

        function void check_result(t_row_result got);
            t_row_result want;
            if (expected_q.size() == 0) begin
                flag("output word with nothing pending, column", '0, got.column);
                return;
            end
            want = expected_q.pop_front();
            if (got.column !== want.column)
                flag("column", want.column, got.column);
            if (got.value !== want.value)
                flag("value", want.value, got.value);
            if (got.last_in_row !== want.last_in_row)
                flag("last_in_row", want.last_in_row, got.last_in_row);
            if (got.row_empty !== want.row_empty)
                flag("row_empty", want.row_empty, got.row_empty);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                     clk         = 1'b0;
    logic                     rst_n       = 1'b0;
    logic                     in_valid    = 1'b0;
    logic                     in_ready;
    logic signed [DATA_W-1:0] a_value     = '0;
    logic [COL_W-1:0]         b_column    = '0;
    logic signed [DATA_W-1:0] b_value     = '0;
    logic                     has_product = 1'b0;
    logic                     end_of_row  = 1'b0;
    logic                     out_valid;
    logic                     out_ready   = 1'b0;
    logic [COL_W-1:0]         out_column;
    logic signed [VAL_W-1:0]  out_value;
    logic                     out_last_in_row;
    logic                     out_row_empty;

    int            send_idle_pct  = 0;
    int            recv_stall_pct = 0;
    int            quiet_cycles   = 0;
    row_scoreboard board          = new();

    sparse_row_product_accumulator u_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_a_value     (a_value),
        .i_b_column    (b_column),
        .i_b_value     (b_value),
        .i_has_product (has_product),
        .i_end_of_row  (end_of_row),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_column      (out_column),
        .o_value       (out_value),
        .o_last_in_row (out_last_in_row),
        .o_row_empty   (out_row_empty)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Stall the output side at random; at zero percent ready stays high.
    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Sample both handshakes at the edge: note accepted input words, check
    // accepted output words, and count edges where nothing moves.
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready)
                board.note_word(a_value, b_column, b_value, has_product, end_of_row);
            if (out_valid && out_ready)
                board.check_result('{out_column, out_value, out_last_in_row, out_row_empty});
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("sparse_row_product_accumulator: mismatch");
                $finish;
            end
        end
    end

    // Present one input word and hold it until taken. Valid stays high on return,
    // so the next call either replaces the payload or drops valid for an idle gap.
    task automatic send_word(input logic signed [DATA_W-1:0] a, input logic [COL_W-1:0] col,
                             input logic signed [DATA_W-1:0] b, input logic prod,
                             input logic eor);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        a_value     <= a;
        b_column    <= col;
        b_value     <= b;
        has_product <= prod;
        end_of_row  <= eor;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Hold off the sender until every pending output word has come back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    // Mostly random full-scale values, with a share of extremes and of small
    // magnitudes so that sums both stay exact and run into saturation.
    function automatic logic signed [DATA_W-1:0] random_q();
        case ($urandom_range(7))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2:       return DATA_W'($urandom_range(1 << 19)) - (1 << 18);
            default: return $urandom;
        endcase
    endfunction

    // One output row: a run of product words, closed either on the last product
    // or by a separate closer word with junk payload. A narrow column window
    // forces repeated touches; a sweep touches every column once, in random order.
    task automatic send_row(input bit sweep, inout int items);
        int col_order [COLUMNS];
        int len;
        int span;
        int base;
        int pick;
        int j;
        int tmp;
        bit closer;
        if (sweep) begin
            for (int i = 0; i < COLUMNS; i++)
                col_order[i] = i;
            for (int i = COLUMNS - 1; i > 0; i--) begin
                j            = $urandom_range(i);
                tmp          = col_order[i];
                col_order[i] = col_order[j];
                col_order[j] = tmp;
            end
            len = COLUMNS;
        end else if ($urandom_range(11) == 0) begin
            len = 0;
        end else begin
            len = $urandom_range(1, 10);
        end
        span   = $urandom_range(1) ? 4 : COLUMNS;
        base   = $urandom_range(COLUMNS - 1);
        closer = (len == 0) || ($urandom_range(1) == 1);
        for (int k = 0; k < len; k++) begin
            // Drop in a flagless word now and then; the block must ignore it.
            if ($urandom_range(9) == 0)
                send_word($urandom, COL_W'($urandom), $urandom, 1'b0, 1'b0);
            pick = sweep ? col_order[k] : (base + $urandom_range(span - 1)) % COLUMNS;
            send_word(random_q(), COL_W'(pick), random_q(), 1'b1, (k == len - 1) && !closer);
            items++;
        end
        if (closer) begin
            send_word($urandom, COL_W'($urandom), $urandom, 1'b0, 1'b1);
            items++;
        end
    endtask

    initial begin
        int items;
        bit swept;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Empty row straight out of reset, then a flagless word (no output).
        send_word(32'sh0, 6'd0, 32'sh0, 1'b0, 1'b1);
        send_word(32'sh5A5A_A5A5, 6'd63, 32'shA5A5_5A5A, 1'b0, 1'b0);
        // Product and row end on the same word: 1.0 * 2.5.
        send_word(Q_ONE, 6'd5, 32'sh0002_8000, 1'b1, 1'b1);
        // Extremes: MAX^2 at the top column, MIN^2 twice into column 0 (clamps
        // high), -1 ulp * 1 ulp floors to -1 ulp, MIN*MAX three times clamps low,
        // then a positive add out of the clamped value. Closer carries junk.
        send_word(Q_MAX, 6'd63, Q_MAX, 1'b1, 1'b0);
        send_word(Q_MIN, 6'd0, Q_MIN, 1'b1, 1'b0);
        send_word(Q_MIN, 6'd0, Q_MIN, 1'b1, 1'b0);
        send_word(32'shFFFF_FFFF, 6'd31, 32'sh1, 1'b1, 1'b0);
        send_word(Q_MIN, 6'd62, Q_MAX, 1'b1, 1'b0);
        send_word(Q_MIN, 6'd62, Q_MAX, 1'b1, 1'b0);
        send_word(Q_MIN, 6'd62, Q_MAX, 1'b1, 1'b0);
        send_word(Q_MAX, 6'd62, Q_MAX, 1'b1, 1'b0);
        send_word(32'sh7777_1234, 6'd17, 32'sh4321_8888, 1'b0, 1'b1);
        // Bitmap must be clear again: another empty row.
        send_word(32'sh0, 6'd0, 32'sh0, 1'b0, 1'b1);
        // Column 5 reused in a new row loads fresh, no stale add: 3.0 * 1.0.
        send_word(32'sh0003_0000, 6'd5, Q_ONE, 1'b1, 1'b0);
        // A zero product still marks its column as touched.
        send_word(32'sh0, 6'd10, Q_MAX, 1'b1, 1'b0);
        send_word(-Q_ONE, 6'd42, 32'sh0000_8000, 1'b1, 1'b1);
        wait_drained();

        // Random rows over four idling phases, draining between phases.
        swept = 1'b0;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 68;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 68;
                end
                default: begin
                    send_idle_pct  = 21;
                    recv_stall_pct = 21;
                end
            endcase
            items = 0;
            while (items < PHASE_ITEMS) begin
                send_row(phase == 2 && !swept, items);
                if (phase == 2)
                    swept = 1'b1;
            end
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("sparse_row_product_accumulator: match");
        else
            $display("sparse_row_product_accumulator: mismatch");
        $finish;
    end

endmodule
